// File: src/qcit_pkg.sv
// shared types and constants for the quorum commit index tracker
`timescale 1ns / 1ps

package qcit_pkg;

    // width of a log index
    localparam int IDX_W = 63;

    // width of slot counts, ranks and hit tallies (covers up to 63 slots)
    localparam int CNT_W = 6;

    // configuration register indexes
    localparam logic REG_FOLLOWER_COUNT = 1'b0;
    localparam logic REG_QUORUM_SIZE    = 1'b1;

    // per-cell control from the sequencer
    typedef struct packed {
        logic shift;
        logic wr_en;
    } cell_ctrl_t;

endpackage

// File: src/qcit_cell.sv
// one slot of the match table ring: holds a match index and its home slot tag
`timescale 1ns / 1ps

module qcit_cell #(
    parameter int TAG_W = 3,
    parameter int POS   = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  qcit_pkg::cell_ctrl_t        ctrl,
    input  logic [qcit_pkg::IDX_W-1:0]  wr_value,
    input  logic [qcit_pkg::IDX_W-1:0]  nb_value,
    input  logic [TAG_W-1:0]            nb_tag,
    input  logic [qcit_pkg::IDX_W-1:0]  probe_value,
    input  logic [TAG_W-1:0]            probe_tag,
    input  logic [qcit_pkg::CNT_W-1:0]  n_active,
    output logic [qcit_pkg::IDX_W-1:0]  value,
    output logic [TAG_W-1:0]            tag,
    output logic                        hit
);

    logic [qcit_pkg::IDX_W-1:0] value_reg;
    logic [TAG_W-1:0]           tag_reg;
    logic                       active;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
            tag_reg   <= TAG_W'(POS);
        end
        else if (ctrl.shift)
        begin
            value_reg <= nb_value;
            tag_reg   <= nb_tag;
        end
        else if (ctrl.wr_en)
        begin
            value_reg <= wr_value;
        end
    end

    // ranks below the probe: smaller value, or equal value from a lower slot
    always_comb
    begin
        active = qcit_pkg::CNT_W'(tag_reg) < n_active;
        hit    = active && ((value_reg < probe_value) ||
                            ((value_reg == probe_value) && (tag_reg < probe_tag)));
    end

    assign value = value_reg;
    assign tag   = tag_reg;

endmodule

// File: src/quorum_commit_index_tracker.sv
// top level of the quorum commit index tracker: handshakes, sequencer and cell ring
`timescale 1ns / 1ps

// channel   direction  tdata fields (lowest bit first)
// s_axis    in         follower[2:0], match_index[65:3], journal_commit_index[128:66]
// m_axis    out        commit_index[62:0], commit_written[63], lagging[64], rejected[65]
// cfg       in         cfg_index 0 follower_count, 1 quorum_size, data in cfg_data[3:0]
//
// an item goes from accept through the slot check and, when the commit candidate is
// recomputed, a rank walk rotating the ring over all cells and the decision, to output
// one item is in flight at a time; a new request is taken once the result is in
// the output register, which holds it while m_axis_tready is low
// reset clears the table, commit index, lagging flag and registers at once; quorum size resets to 1

module quorum_commit_index_tracker #(
    parameter int MAX_FOLLOWERS = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,   // follower, match_index, journal_commit_index
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata,   // commit_index, commit_written, lagging, rejected
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [3:0]   cfg_data
);

    localparam int TAG_W = (MAX_FOLLOWERS > 1) ? $clog2(MAX_FOLLOWERS) : 1;
    localparam int IW    = qcit_pkg::IDX_W;
    localparam int CW    = qcit_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RANK,
        S_DECIDE,
        S_OUT
    } state_t;

    state_t            state_reg;
    logic [2:0]        slot_reg;
    logic [IW-1:0]     newv_reg;
    logic [IW-1:0]     jci_reg;
    logic [TAG_W-1:0]  step_reg;
    logic [IW-1:0]     cand_reg;
    logic [IW-1:0]     commit_reg;
    logic              lagging_reg;
    logic              written_reg;
    logic              rejected_reg;
    logic [3:0]        fc_reg;
    logic [3:0]        qs_reg;
    logic              out_valid_reg;
    logic [IW-1:0]     out_commit_reg;
    logic              out_written_reg;
    logic              out_lagging_reg;
    logic              out_rejected_reg;

    logic [IW-1:0]     val_w [MAX_FOLLOWERS];
    logic [TAG_W-1:0]  tag_w [MAX_FOLLOWERS];
    logic [MAX_FOLLOWERS-1:0] hit_w;
    qcit_pkg::cell_ctrl_t ctrl_w [MAX_FOLLOWERS];

    logic [CW-1:0]     n_act;
    logic [CW-1:0]     q_ext;
    logic [CW-1:0]     k_rank;
    logic [CW-1:0]     hit_cnt;
    logic              slot_ok;
    logic [IW-1:0]     old_value;
    logic              is_reject;
    logic              do_write;
    logic              probe_active;
    logic              out_free;

    always_comb
    begin
        n_act = (CW'(fc_reg) > CW'(MAX_FOLLOWERS)) ? CW'(MAX_FOLLOWERS) : CW'(fc_reg);
        q_ext = CW'(qs_reg);
        // quorum of 0 or 1 takes the largest active entry
        if (q_ext > n_act + CW'(1))
            k_rank = '0;
        else if (q_ext < CW'(2))
            k_rank = n_act - CW'(1);
        else
            k_rank = n_act + CW'(1) - q_ext;

        slot_ok   = CW'(slot_reg) < CW'(MAX_FOLLOWERS);
        old_value = '0;
        for (int p = 0; p < MAX_FOLLOWERS; p++)
        begin
            if (CW'(p) == CW'(slot_reg))
                old_value = val_w[p];
        end
        is_reject = newv_reg < old_value;
        do_write  = (state_reg == S_CHECK) && slot_ok && !is_reject;

        hit_cnt = '0;
        for (int p = 0; p < MAX_FOLLOWERS; p++)
        begin
            hit_cnt = hit_cnt + CW'(hit_w[p]);
        end
        probe_active = CW'(tag_w[0]) < n_act;
        out_free     = !out_valid_reg || m_axis_tready;
    end

    // ring: each cell takes its upper neighbor, cell 0 is the probe head
    for (genvar p = 0; p < MAX_FOLLOWERS; p++)
    begin : g_cell
        localparam int NB = (p + 1) % MAX_FOLLOWERS;

        assign ctrl_w[p].shift = (state_reg == S_RANK);
        assign ctrl_w[p].wr_en = do_write && (CW'(p) == CW'(slot_reg));

        qcit_cell #(
            .TAG_W (TAG_W),
            .POS   (p)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl_w[p]),
            .wr_value    (newv_reg),
            .nb_value    (val_w[NB]),
            .nb_tag      (tag_w[NB]),
            .probe_value (val_w[0]),
            .probe_tag   (tag_w[0]),
            .n_active    (n_act),
            .value       (val_w[p]),
            .tag         (tag_w[p]),
            .hit         (hit_w[p])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            slot_reg         <= '0;
            newv_reg         <= '0;
            jci_reg          <= '0;
            step_reg         <= '0;
            cand_reg         <= '0;
            commit_reg       <= '0;
            lagging_reg      <= 1'b0;
            written_reg      <= 1'b0;
            rejected_reg     <= 1'b0;
            fc_reg           <= 4'd0;
            qs_reg           <= 4'd1;
            out_valid_reg    <= 1'b0;
            out_commit_reg   <= '0;
            out_written_reg  <= 1'b0;
            out_lagging_reg  <= 1'b0;
            out_rejected_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    qcit_pkg::REG_FOLLOWER_COUNT: fc_reg <= cfg_data;
                    qcit_pkg::REG_QUORUM_SIZE:    qs_reg <= cfg_data;
                    default:                      ;
                endcase
            end

            // the output stage reloads the register itself when it fires
            if (out_valid_reg && m_axis_tready && (state_reg != S_OUT))
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        slot_reg     <= s_axis_tdata[2:0];
                        newv_reg     <= s_axis_tdata[65:3];
                        jci_reg      <= s_axis_tdata[128:66];
                        written_reg  <= 1'b0;
                        rejected_reg <= 1'b0;
                        state_reg    <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (!slot_ok)
                        state_reg <= S_OUT;
                    else if (is_reject)
                    begin
                        rejected_reg <= 1'b1;
                        state_reg    <= S_OUT;
                    end
                    else if ((newv_reg > commit_reg) && (n_act != '0))
                    begin
                        step_reg  <= '0;
                        state_reg <= S_RANK;
                    end
                    else
                        state_reg <= S_OUT;
                end
                S_RANK:
                begin
                    // exactly one active entry has the wanted rank
                    if (probe_active && (hit_cnt == k_rank))
                        cand_reg <= val_w[0];
                    step_reg <= step_reg + TAG_W'(1);
                    if (step_reg == TAG_W'(MAX_FOLLOWERS - 1))
                        state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    if (cand_reg < jci_reg)
                        lagging_reg <= 1'b1;
                    else
                    begin
                        lagging_reg <= 1'b0;
                        commit_reg  <= cand_reg;
                        written_reg <= 1'b1;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        out_commit_reg   <= commit_reg;
                        out_written_reg  <= written_reg;
                        out_lagging_reg  <= lagging_reg;
                        out_rejected_reg <= rejected_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_rejected_reg, out_lagging_reg, out_written_reg,
                            out_commit_reg};

    // a rejected request never pushes a commit index
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(out_rejected_reg && out_written_reg))
        else $error("rejected and written in the same result");

    // a pushed commit index always clears the lagging flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_written_reg) |-> !out_lagging_reg)
        else $error("written result still lagging");

    // the ring is back at its home position whenever a request can be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (tag_w[0] == '0))
        else $error("cell ring not at home position while idle");

    // a rank walk always ends in the commit decision
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_RANK) && (step_reg == TAG_W'(MAX_FOLLOWERS - 1)))
            |=> (state_reg == S_DECIDE))
        else $error("rank walk did not end in decision");

endmodule
